FILE: rtl/swa_rr_pkg.sv
// Shared types and codes for the round-robin switch allocator.
// Holds the transaction structs, operation and error codes, and the FSM state type.
// No dependencies; used by switch_allocator_round_robin.
package swa_rr_pkg;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_PICK    = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PICK
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [2:0] out_port;
    logic [1:0] out_vc;
    logic [2:0] in_port;
    logic [1:0] in_vc;
  } in_item_t;

  typedef struct packed {
    logic       grant_valid;
    logic [2:0] grant_port;
    logic [1:0] grant_vc;
    logic       slot_requested;
    logic       all_empty;
    err_t       error_code;
  } out_item_t;

endpackage

FILE: rtl/switch_allocator_round_robin.sv
// Round-robin switch allocator: request rows, stored requester VCs and per-port grant state.
// Depends on swa_rr_pkg for the transaction structs, codes and the FSM state type.
// Request rows and requester VCs live in synchronous memories with a registered read.
//
//   channel   ports                      handshake
//   --------  -------------------------  ------------------------------------------
//   input     start, busy, in_item       accepted at an edge with start=1, busy=0
//   result    out_valid, out_item        one-cycle strobe, no back-pressure
//
// A request, clear or tick, a repeated pick and any erroring transaction pass through the
// execute state before the result strobe: the addressed request row is read from its memory
// on acceptance, then updated and the result registered. A fresh pick also passes through
// the pick state, because the winner's stored VC is read from the VC memory after the row scan.
// The next transaction may be accepted in the cycle the previous result is strobed.
// Reset is synchronous and clears all row-valid flags, so no clearing pass is needed.
// The receiver cannot stall; every result is shown for exactly one cycle.
module switch_allocator_round_robin #(
  parameter int NUM_PORTS = 5,
  parameter int NUM_VCS   = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  swa_rr_pkg::in_item_t   in_item,
  output logic                   out_valid,
  output swa_rr_pkg::out_item_t  out_item
);

  localparam int SLOTS = NUM_PORTS * NUM_VCS;
  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = $clog2(NUM_PORTS);
  localparam int VAW   = $clog2(SLOTS * NUM_PORTS);

  // Control and transaction registers.
  swa_rr_pkg::state_t    state_r, state_nxt;
  swa_rr_pkg::in_item_t  item_r;
  swa_rr_pkg::out_item_t out_item_r, out_item_nxt;
  swa_rr_pkg::out_item_t pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Request-row memory, one row per output port. A row that was never written since
  // reset has its valid flag low and reads as all zero.
  logic [SLOTS-1:0]     row_mem [NUM_PORTS];
  logic [SLOTS-1:0]     row_q;
  logic                 row_vld_q;
  logic [NUM_PORTS-1:0] row_vld_r;
  logic [NUM_PORTS-1:0] nz_r;        // row holds at least one request bit

  // Requester-VC memory, indexed by output port and slot.
  logic [1:0]     vc_mem [SLOTS * NUM_PORTS];
  logic [1:0]     vc_q;

  // Per-port round-robin and grant-hold state.
  logic [SW-1:0]        last_slot_r [NUM_PORTS];
  logic [4:0]           held_r      [NUM_PORTS];
  logic [NUM_PORTS-1:0] picked_r;

  // Slot number to input port, worked out at elaboration.
  logic [2:0] slot_port_tab [SLOTS];
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot_port
    localparam int SlotPort = g / NUM_VCS;
    assign slot_port_tab[g] = 3'(SlotPort);
  end

  // Read address of the row memory, taken straight from the accepted transaction.
  logic          accept;
  logic [PW-1:0] rd_idx;
  assign accept = start && !busy;
  assign rd_idx = ({1'b0, in_item.out_port} < 4'(NUM_PORTS)) ? in_item.out_port[PW-1:0]
                                                              : '0;

  // Decoded fields of the transaction in flight.
  logic             op_ok, ip_ok, ovc_ok, slot_ok;
  logic [PW-1:0]    op_idx;
  logic [5:0]       slot_full;
  logic [SW-1:0]    slot_idx;
  logic [SLOTS-1:0] row_eff;
  logic             slot_bit;

  assign op_ok     = {1'b0, item_r.out_port} < 4'(NUM_PORTS);
  assign ip_ok     = {1'b0, item_r.in_port} < 4'(NUM_PORTS);
  assign ovc_ok    = {1'b0, item_r.out_vc} < 3'(NUM_VCS);
  assign slot_ok   = op_ok && ip_ok && ovc_ok;
  assign op_idx    = item_r.out_port[PW-1:0];
  assign slot_full = 6'(item_r.in_port) * 6'(NUM_VCS) + 6'(item_r.out_vc);
  assign slot_idx  = slot_full[SW-1:0];
  assign row_eff   = row_vld_q ? row_q : '0;
  assign slot_bit  = slot_ok && row_eff[slot_idx];

  // Rotating priority encoder: the first set bit above the last granted slot, else the
  // first set bit of the row, which covers the wrap back to and including that slot.
  logic [SW-1:0] start_slot, hi_win, lo_win, win;
  logic          hi_found, lo_found;

  assign start_slot = last_slot_r[op_idx];

  always_comb begin
    hi_win   = '0;
    lo_win   = '0;
    hi_found = 1'b0;
    lo_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (row_eff[i] && (SW'(i) > start_slot) && !hi_found) begin
        hi_win   = SW'(i);
        hi_found = 1'b1;
      end
      if (row_eff[i] && !lo_found) begin
        lo_win   = SW'(i);
        lo_found = 1'b1;
      end
    end
  end

  assign win = hi_found ? hi_win : lo_win;

  // Next state, memory strobes and the result of the transaction.
  logic             row_we, vc_we, pick_go, tick_clr;
  logic [SLOTS-1:0] new_row;
  logic [NUM_PORTS-1:0] nz_after;
  logic [VAW-1:0]   vc_addr;
  swa_rr_pkg::out_item_t res;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pend_nxt      = pend_r;
    row_we        = 1'b0;
    vc_we         = 1'b0;
    pick_go       = 1'b0;
    tick_clr      = 1'b0;
    new_row       = row_eff;
    res           = '0;
    res.error_code = swa_rr_pkg::ERR_OK;

    unique case (item_r.func) inside
      swa_rr_pkg::FUNC_REQUEST, swa_rr_pkg::FUNC_CLEAR: begin
        if (!slot_ok) begin
          res.error_code = swa_rr_pkg::ERR_RANGE;
        end else begin
          row_we = 1'b1;
          if (item_r.func == swa_rr_pkg::FUNC_REQUEST) begin
            new_row = row_eff | (SLOTS'(1) << slot_idx);
            vc_we   = 1'b1;
            res.slot_requested = 1'b1;
          end else begin
            new_row = row_eff & ~(SLOTS'(1) << slot_idx);
          end
        end
      end
      swa_rr_pkg::FUNC_PICK: begin
        res.slot_requested = slot_bit;
        if (!op_ok) begin
          res.error_code = swa_rr_pkg::ERR_RANGE;
        end else if (picked_r[op_idx]) begin
          res.grant_valid = 1'b1;
          res.grant_port  = held_r[op_idx][4:2];
          res.grant_vc    = held_r[op_idx][1:0];
        end else if (!lo_found) begin
          res.error_code = swa_rr_pkg::ERR_EMPTY;
        end else begin
          pick_go         = 1'b1;
          res.grant_valid = 1'b1;
          res.grant_port  = slot_port_tab[win];
        end
      end
      swa_rr_pkg::FUNC_TICK: begin
        res.slot_requested = slot_bit;
        tick_clr = 1'b1;
      end
      default: begin
        res.error_code = swa_rr_pkg::ERR_OK;
      end
    endcase

    nz_after = nz_r;
    if (row_we) begin
      nz_after[op_idx] = |new_row;
    end
    res.all_empty = ~|nz_after;

    unique case (state_r)
      swa_rr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = swa_rr_pkg::ST_EXEC;
        end
      end
      swa_rr_pkg::ST_EXEC: begin
        if (pick_go) begin
          pend_nxt  = res;
          state_nxt = swa_rr_pkg::ST_PICK;
        end else begin
          out_item_nxt  = res;
          out_valid_nxt = 1'b1;
          state_nxt     = swa_rr_pkg::ST_IDLE;
        end
      end
      swa_rr_pkg::ST_PICK: begin
        out_item_nxt          = pend_r;
        out_item_nxt.grant_vc = vc_q;
        out_valid_nxt         = 1'b1;
        state_nxt             = swa_rr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = swa_rr_pkg::ST_IDLE;
      end
    endcase

    // Not in the execute cycle, nothing is written.
    if (state_r != swa_rr_pkg::ST_EXEC) begin
      row_we   = 1'b0;
      vc_we    = 1'b0;
      pick_go  = 1'b0;
      tick_clr = 1'b0;
    end
  end

  // The VC memory is written by a request and read by a fresh pick; both happen only in
  // the execute cycle and never together, so one address serves both.
  assign vc_addr = VAW'(op_idx) * VAW'(SLOTS) + (pick_go ? VAW'(win) : VAW'(slot_idx));

  // Memories.
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[op_idx] <= new_row;
    end
    row_q <= row_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (vc_we) begin
      vc_mem[vc_addr] <= item_r.in_vc;
    end
    vc_q <= vc_mem[vc_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == swa_rr_pkg::ST_IDLE) begin
      row_vld_q <= row_vld_r[rd_idx];
    end
    out_item_r <= out_item_nxt;
    pend_r     <= pend_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swa_rr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      nz_r        <= '0;
      picked_r    <= '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        last_slot_r[p] <= '0;
        held_r[p]      <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (row_we) begin
        row_vld_r[op_idx] <= 1'b1;
        nz_r              <= nz_after;
      end
      if (tick_clr) begin
        picked_r <= '0;
      end
      if (pick_go) begin
        picked_r[op_idx]    <= 1'b1;
        last_slot_r[op_idx] <= win;
      end
      if (state_r == swa_rr_pkg::ST_PICK) begin
        held_r[op_idx] <= {pend_r.grant_port, vc_q};
      end
    end
  end

  assign busy      = (state_r != swa_rr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result strobe follows only an execute or VC-read cycle.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == swa_rr_pkg::ST_EXEC ||
                   $past(state_r) == swa_rr_pkg::ST_PICK))
    else $error("result strobe without a transaction in execution");

  // A grant never comes with an error.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.grant_valid |-> out_item.error_code == swa_rr_pkg::ERR_OK)
    else $error("grant reported together with an error");

  // An empty switch cannot report the addressed slot as requested.
  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.all_empty |-> !out_item.slot_requested)
    else $error("slot requested while all rows are empty");

  // A fresh pick always marks its port as granted for the rest of the tick.
  a_pick_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == swa_rr_pkg::ST_PICK |-> picked_r[op_idx])
    else $error("fresh pick did not set the grant-hold flag");

endmodule

FILE: tb/sv/swa_rr_checker.sv
// Result checker for the round-robin switch allocator: predicts every result and compares it.
// Depends on swa_rr_pkg for the transaction structs and the operation and error codes.
// Watches the command channel and the result strobe only; it drives nothing into the block.
module swa_rr_checker
  import swa_rr_pkg::*;
#(
  parameter int NUM_PORTS = 5,
  parameter int NUM_VCS   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        mismatches,
  output int        outstanding,
  output int        compared,
  output int        grants
);

  localparam int SLOTS = NUM_PORTS * NUM_VCS;

  // Model state: one request row per output port plus the round-robin pointers.
  logic [SLOTS-1:0] req_row         [NUM_PORTS];
  logic [1:0]       req_vc          [NUM_PORTS][SLOTS];
  int unsigned      prev_slot       [NUM_PORTS];
  logic [4:0]       held            [NUM_PORTS];
  logic             granted_in_tick [NUM_PORTS];

  out_item_t predicted_q [$];
  out_item_t want;

  function automatic string fields(out_item_t r);
    return $sformatf("gv=%0d port=%0d vc=%0d req=%0d empty=%0d err=%0d", r.grant_valid,
                     r.grant_port, r.grant_vc, r.slot_requested, r.all_empty, r.error_code);
  endfunction

  // Applies one command to the model state and returns the result it should produce.
  function automatic out_item_t allocate(in_item_t t);
    out_item_t   r;
    int unsigned op, ip, ovc, slot, s, i;
    logic        slot_ok, found, any_set;
    logic [2:0]  gp;
    r = '0;
    r.error_code = ERR_OK;
    op = 32'(t.out_port);
    ip = 32'(t.in_port);
    ovc = 32'(t.out_vc);
    slot = ip * NUM_VCS + ovc;
    slot_ok = (op < NUM_PORTS) && (ip < NUM_PORTS) && (ovc < NUM_VCS);
    case (t.func)
      FUNC_REQUEST, FUNC_CLEAR: begin
        if (!slot_ok) begin
          r.error_code = ERR_RANGE;
        end else if (t.func == FUNC_REQUEST) begin
          req_row[op][slot] = 1'b1;
          req_vc[op][slot] = t.in_vc;
        end else begin
          req_row[op][slot] = 1'b0;
        end
      end
      FUNC_PICK: begin
        if (op >= NUM_PORTS) begin
          r.error_code = ERR_RANGE;
        end else if (granted_in_tick[op]) begin
          // The grant of this tick is repeated even if its request is gone.
          r.grant_valid = 1'b1;
          r.grant_port = held[op][4:2];
          r.grant_vc = held[op][1:0];
        end else begin
          found = 1'b0;
          for (i = 1; i <= SLOTS; i++) begin
            s = (prev_slot[op] + i) % SLOTS;
            if (!found && req_row[op][s]) begin
              found = 1'b1;
              gp = 3'(s / NUM_VCS);
              prev_slot[op] = s;
              held[op] = {gp, req_vc[op][s]};
              granted_in_tick[op] = 1'b1;
              r.grant_valid = 1'b1;
              r.grant_port = gp;
              r.grant_vc = req_vc[op][s];
            end
          end
          if (!found) r.error_code = ERR_EMPTY;
        end
      end
      default: begin
        for (i = 0; i < NUM_PORTS; i++) granted_in_tick[i] = 1'b0;
      end
    endcase
    if (slot_ok) r.slot_requested = req_row[op][slot];
    any_set = 1'b0;
    for (i = 0; i < NUM_PORTS; i++) begin
      if (req_row[i] != '0) any_set = 1'b1;
    end
    r.all_empty = !any_set;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        req_row[p] = '0;
        prev_slot[p] = 0;
        held[p] = '0;
        granted_in_tick[p] = 1'b0;
      end
      predicted_q.delete();
      mismatches = 0;
      compared = 0;
      grants = 0;
      outstanding = 0;
    end else begin
      // A result can never belong to the command accepted at the same edge,
      // so the comparison runs before the new prediction is queued.
      if (out_valid) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", fields(out_item));
        end else begin
          want = predicted_q.pop_front();
          compared++;
          if (out_item.grant_valid === 1'b1) grants++;
          if (out_item.grant_valid !== want.grant_valid ||
              out_item.grant_port !== want.grant_port ||
              out_item.grant_vc !== want.grant_vc ||
              out_item.slot_requested !== want.slot_requested ||
              out_item.all_empty !== want.all_empty ||
              out_item.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected %s, got %s", fields(want), fields(out_item));
            end
          end
        end
      end
      if (start && !busy) predicted_q.push_back(allocate(in_item));
      outstanding = predicted_q.size();
    end
  end

endmodule

FILE: tb/sv/switch_allocator_round_robin_test.sv
// Top-level testbench for the round-robin switch allocator: clock, reset, stimulus, verdict.
// Depends on swa_rr_pkg, the block switch_allocator_round_robin and the checker swa_rr_checker.
// A directed sequence walks the corner cases, then random commands run with random idle gaps.
module switch_allocator_round_robin_test;
  import swa_rr_pkg::*;

  localparam int NUM_PORTS    = 5;
  localparam int NUM_VCS      = 4;
  localparam int RANDOM_ITEMS = 600;
  // The slowest correct run needs roughly 650 commands, each with its result latency and the
  // longest idle gap; the limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  int mismatches, outstanding, compared, grants;
  int cycles = 0;
  int sent [4];

  // Random-phase knobs. A narrow phase squeezes traffic into a few slots so that rows
  // fill, wrap and empty quickly; a draining phase favors clears over requests; a burst
  // phase sends back to back with no idle cycles at all.
  bit narrow, draining, burst;

  switch_allocator_round_robin #(
    .NUM_PORTS(NUM_PORTS),
    .NUM_VCS  (NUM_VCS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  swa_rr_checker #(
    .NUM_PORTS(NUM_PORTS),
    .NUM_VCS  (NUM_VCS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .compared   (compared),
    .grants     (grants)
  );

  always #5 clk = ~clk;

  // The run is cut off if the block ever stops answering.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t cmd(func_t f, int op, int ovc, int ip, int ivc);
    in_item_t t;
    t.func = f;
    t.out_port = 3'(op);
    t.out_vc = 2'(ovc);
    t.in_port = 3'(ip);
    t.in_vc = 2'(ivc);
    return t;
  endfunction

  // Mostly in-range commands so that picks find requesters; about one port index in
  // twenty is drawn from the full field so that range errors keep occurring.
  function automatic in_item_t random_cmd();
    int    r, hi_p, hi_v;
    func_t f;
    hi_p = narrow ? 1 : NUM_PORTS - 1;
    hi_v = narrow ? 1 : NUM_VCS - 1;
    r = $urandom_range(99);
    if (draining) begin
      f = (r < 15) ? FUNC_REQUEST : (r < 70) ? FUNC_CLEAR : (r < 90) ? FUNC_PICK : FUNC_TICK;
    end else begin
      f = (r < 40) ? FUNC_REQUEST : (r < 55) ? FUNC_CLEAR : (r < 85) ? FUNC_PICK : FUNC_TICK;
    end
    return cmd(f,
               ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(hi_p),
               $urandom_range(hi_v),
               ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(hi_p),
               $urandom_range(3));
  endfunction

  // Presents one transaction at a falling edge and holds it until the block takes it,
  // that is until a rising edge sees busy low.
  task automatic issue(in_item_t t);
    @(negedge clk);
    start = 1'b1;
    in_item = t;
    sent[t.func]++;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for the idle gap given by n, with junk on the command fields meanwhile.
  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      in_item = in_item_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  initial begin
    int n, g, r;

    // Reset is held low from time zero and released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Slot numbers below are in_port * NUM_VCS + out_vc.
    issue(cmd(FUNC_PICK,    0, 0, 0, 0)); // pick before the first tick on an empty port
    issue(cmd(FUNC_REQUEST, 7, 3, 7, 3)); // all fields at their maximum, range error
    issue(cmd(FUNC_REQUEST, 0, 3, 4, 3)); // highest slot of port 0
    idle($urandom_range(2));
    issue(cmd(FUNC_REQUEST, 0, 0, 2, 1));
    issue(cmd(FUNC_PICK,    0, 0, 2, 0)); // scan starts after slot 0 and finds slot 8
    issue(cmd(FUNC_PICK,    0, 0, 2, 0)); // repeated pick in the same tick
    issue(cmd(FUNC_CLEAR,   0, 0, 2, 0));
    idle($urandom_range(2));
    issue(cmd(FUNC_PICK,    0, 0, 2, 0)); // held grant survives the clear of its request
    issue(cmd(FUNC_TICK,    0, 0, 0, 0));
    issue(cmd(FUNC_PICK,    0, 3, 4, 0)); // advances to slot 19
    issue(cmd(FUNC_REQUEST, 0, 0, 2, 2)); // rewrite slot 8 with another input VC
    idle($urandom_range(2));
    issue(cmd(FUNC_PICK,    5, 0, 0, 0)); // output port out of range
    issue(cmd(FUNC_PICK,    0, 0, 7, 0)); // held grant, addressed slot out of range
    issue(cmd(FUNC_CLEAR,   5, 0, 0, 0)); // output port out of range
    issue(cmd(FUNC_REQUEST, 1, 1, 5, 2)); // input port out of range
    issue(cmd(FUNC_TICK,    0, 0, 0, 0));
    issue(cmd(FUNC_PICK,    0, 0, 2, 0)); // wraps from slot 19 around to slot 8
    issue(cmd(FUNC_REQUEST, 4, 3, 4, 0));
    idle($urandom_range(2));
    issue(cmd(FUNC_PICK,    4, 3, 4, 0)); // lone request in the last slot of port 4
    issue(cmd(FUNC_TICK,    0, 0, 0, 0));
    issue(cmd(FUNC_PICK,    4, 3, 4, 0)); // the wrap includes the last granted slot itself
    issue(cmd(FUNC_CLEAR,   0, 3, 4, 0));
    issue(cmd(FUNC_CLEAR,   0, 0, 2, 0));
    issue(cmd(FUNC_CLEAR,   4, 3, 4, 0)); // every row is empty again
    issue(cmd(FUNC_TICK,    0, 0, 0, 0));
    issue(cmd(FUNC_PICK,    4, 0, 0, 0)); // no requester after the tick

    // Random part. Gaps are mostly zero or short with an occasional long one, and the
    // phase knobs are redrawn every fifty transactions.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        narrow = ($urandom_range(2) == 0);
        draining = ($urandom_range(2) == 0);
        burst = ($urandom_range(3) == 0);
      end
      issue(random_cmd());
      r = $urandom_range(99);
      g = (burst || r < 55) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(6, 40);
      idle(g);
    end

    // Drain: wait for every predicted result, then a few more cycles so that a stray
    // extra strobe would still be caught.
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Drove %0d requests, %0d clears, %0d picks and %0d ticks.",
             sent[FUNC_REQUEST], sent[FUNC_CLEAR], sent[FUNC_PICK], sent[FUNC_TICK]);
    $display("Checked %0d results, %0d of them grants, with %0d mismatches.",
             compared, grants, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
